// File: hdl/mjdcal_pkg.sv
// ---------------------------------------------------------------------------
// mjdcal_pkg: shared types and constants for the mjd to calendar converter
// Holds the result structs, the reciprocal constants and the month tables.
// ---------------------------------------------------------------------------
package mjdcal_pkg;

  localparam int MJD_W   = 17;
  localparam int SOD_W   = 27;
  localparam int YEAR_W  = 12;
  localparam int DOY_W   = 9;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int SEC_W   = 16;

  // register stages from input to output register
  localparam int PIPE_DEPTH = 5;

  localparam int DAYS_W = 20;

  // days from the proleptic year zero to mjd zero
  localparam logic [DAYS_W-1:0] YEAR_BIAS  = 20'd678940;
  localparam logic [8:0]        DAYS_YEAR  = 9'd365;
  // floor(2^22 / 365), estimate is low by at most one
  localparam logic [13:0]       RECIP_365  = 14'd11491;
  // ceil(2^17 / 100), exact for values below 4681
  localparam logic [10:0]       RECIP_100  = 11'd1311;

  localparam logic [SOD_W-1:0]  MS_HOUR    = 27'd3600000;
  localparam logic [21:0]       MS_MINUTE  = 22'd60000;
  // floor(2^42 / 3600000) and floor(2^32 / 60000)
  localparam logic [20:0]       RECIP_HOUR = 21'd1221679;
  localparam logic [16:0]       RECIP_MIN  = 17'd71582;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [DOY_W-1:0]   day_of_year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } date_t;

  typedef struct packed {
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic [SEC_W-1:0]  second_ms;
  } tod_t;

  // last day of year of month idx+1, for idx 0 (january) to 10 (november)
  function automatic logic [8:0] month_end(input logic [3:0] idx, input logic leap);
    logic [8:0] d;
    case (idx)
      4'd0:    d = 9'd31;
      4'd1:    d = 9'd59;
      4'd2:    d = 9'd90;
      4'd3:    d = 9'd120;
      4'd4:    d = 9'd151;
      4'd5:    d = 9'd181;
      4'd6:    d = 9'd212;
      4'd7:    d = 9'd243;
      4'd8:    d = 9'd273;
      4'd9:    d = 9'd304;
      4'd10:   d = 9'd334;
      default: d = 9'd365;
    endcase
    if (leap && idx != 4'd0) begin
      d = d + 9'd1;
    end
    return d;
  endfunction

  // days of the year before the first of month mon (1..12)
  function automatic logic [8:0] month_start(input logic [3:0] mon, input logic leap);
    logic [8:0] d;
    if (mon <= 4'd1) begin
      d = 9'd0;
    end else begin
      d = month_end(mon - 4'd2, leap);
    end
    return d;
  endfunction

endpackage

// File: hdl/mjdcal_date.sv
// ---------------------------------------------------------------------------
// mjdcal_date: date path of the mjd to calendar converter
// Five register stages: year estimate, correction, january 1 candidates,
// year choice with day of year, month and day split.
// ---------------------------------------------------------------------------
module mjdcal_date (
  input  logic                          clk,
  input  logic                          en,
  input  logic [mjdcal_pkg::MJD_W-1:0]  mjd,
  output mjdcal_pkg::date_t             date
);

  localparam int NCAND = 3;

  // stage 1
  logic [mjdcal_pkg::DAYS_W-1:0] d1_r, d1_nxt;
  logic [mjdcal_pkg::YEAR_W-1:0] qy1_r, qy1_nxt;
  logic [33:0]                   qy_prod;
  // stage 2
  logic [mjdcal_pkg::DAYS_W-1:0] d2_r;
  logic [mjdcal_pkg::YEAR_W-1:0] y2_r, y2_nxt;
  logic [mjdcal_pkg::DAYS_W-1:0] y_rem;
  // stage 3
  logic [mjdcal_pkg::DAYS_W-1:0] d3_r;
  logic [mjdcal_pkg::YEAR_W-1:0] yc3_r    [NCAND];
  logic [mjdcal_pkg::DAYS_W-1:0] m365_r   [NCAND];
  logic [5:0]                    q100p_r  [NCAND];
  logic [5:0]                    q100y_r  [NCAND];
  logic [mjdcal_pkg::YEAR_W-1:0] yc_nxt   [NCAND];
  logic [mjdcal_pkg::DAYS_W-1:0] m365_nxt [NCAND];
  logic [5:0]                    q100p_nxt[NCAND];
  logic [5:0]                    q100y_nxt[NCAND];
  // stage 4
  logic [mjdcal_pkg::YEAR_W-1:0] y4_r, y4_nxt;
  logic [5:0]                    q100y4_r, q100y4_nxt;
  logic [mjdcal_pkg::DOY_W-1:0]  doy4_r, doy4_nxt;
  logic [mjdcal_pkg::DAYS_W-1:0] ecand[NCAND];
  logic [mjdcal_pkg::DAYS_W-1:0] esel;
  // stage 5
  mjdcal_pkg::date_t             date_r, date_nxt;
  logic                          c100, leap;
  logic [3:0]                    mon;

  // stage 1: d = days since year zero, year estimate by reciprocal of 365
  always_comb begin
    d1_nxt  = mjdcal_pkg::DAYS_W'(mjd) + mjdcal_pkg::YEAR_BIAS;
    qy_prod = 34'(d1_nxt) * 34'(mjdcal_pkg::RECIP_365);
    qy1_nxt = qy_prod[33:22];
  end

  // stage 2: estimate may be one low
  always_comb begin
    y_rem  = d1_r - mjdcal_pkg::DAYS_W'(qy1_r * 21'(mjdcal_pkg::DAYS_YEAR));
    y2_nxt = qy1_r;
    if (y_rem >= mjdcal_pkg::DAYS_W'(mjdcal_pkg::DAYS_YEAR)) begin
      y2_nxt = qy1_r + 12'd1;
    end
  end

  // stage 3: the true year is the estimate or up to two below it
  always_comb begin
    logic [mjdcal_pkg::YEAR_W-1:0] pc;
    logic [22:0]                   pp, py;
    for (int k = 0; k < NCAND; k++) begin
      yc_nxt[k]    = y2_r - mjdcal_pkg::YEAR_W'(k);
      pc           = yc_nxt[k] - 12'd1;
      pp           = 23'(pc) * 23'(mjdcal_pkg::RECIP_100);
      py           = 23'(yc_nxt[k]) * 23'(mjdcal_pkg::RECIP_100);
      q100p_nxt[k] = pp[22:17];
      q100y_nxt[k] = py[22:17];
      m365_nxt[k]  = mjdcal_pkg::DAYS_W'(21'(yc_nxt[k]) * 21'(mjdcal_pkg::DAYS_YEAR));
    end
  end

  // stage 4: days before january 1 of each candidate, take the latest year
  // whose january 1 is not after the input
  always_comb begin
    logic [mjdcal_pkg::YEAR_W-1:0] pc;
    for (int k = 0; k < NCAND; k++) begin
      pc       = yc3_r[k] - 12'd1;
      ecand[k] = m365_r[k] + mjdcal_pkg::DAYS_W'(pc[11:2])
               - mjdcal_pkg::DAYS_W'(q100p_r[k]) + mjdcal_pkg::DAYS_W'(q100p_r[k][5:2]);
    end
    if (ecand[0] <= d3_r) begin
      y4_nxt     = yc3_r[0];
      q100y4_nxt = q100y_r[0];
      esel       = ecand[0];
    end else if (ecand[1] <= d3_r) begin
      y4_nxt     = yc3_r[1];
      q100y4_nxt = q100y_r[1];
      esel       = ecand[1];
    end else begin
      y4_nxt     = yc3_r[2];
      q100y4_nxt = q100y_r[2];
      esel       = ecand[2];
    end
    doy4_nxt = mjdcal_pkg::DOY_W'(d3_r - esel + 20'd1);
  end

  // stage 5: leap rule, then month by parallel compares against month ends
  always_comb begin
    c100 = ((mjdcal_pkg::YEAR_W'(q100y4_r) * 12'd100) == y4_r);
    leap = ((y4_r[1:0] == 2'd0) && !c100) || (c100 && (q100y4_r[1:0] == 2'd0));
    mon  = 4'd1;
    for (int i = 0; i < 11; i++) begin
      if (doy4_r > mjdcal_pkg::month_end(4'(i), leap)) begin
        mon = mon + 4'd1;
      end
    end
    date_nxt.year        = y4_r;
    date_nxt.day_of_year = doy4_r;
    date_nxt.month       = mon;
    date_nxt.day         = mjdcal_pkg::DAY_W'(doy4_r - mjdcal_pkg::month_start(mon, leap));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1_r     <= d1_nxt;
      qy1_r    <= qy1_nxt;
      d2_r     <= d1_r;
      y2_r     <= y2_nxt;
      d3_r     <= d2_r;
      for (int k = 0; k < NCAND; k++) begin
        yc3_r[k]   <= yc_nxt[k];
        m365_r[k]  <= m365_nxt[k];
        q100p_r[k] <= q100p_nxt[k];
        q100y_r[k] <= q100y_nxt[k];
      end
      y4_r     <= y4_nxt;
      q100y4_r <= q100y4_nxt;
      doy4_r   <= doy4_nxt;
      date_r   <= date_nxt;
    end
  end

  assign date = date_r;

endmodule

// File: hdl/mjdcal_tod.sv
// ---------------------------------------------------------------------------
// mjdcal_tod: time of day path of the mjd to calendar converter
// Splits milliseconds into hour, minute and milliseconds in five stages.
// ---------------------------------------------------------------------------
module mjdcal_tod (
  input  logic                          clk,
  input  logic                          en,
  input  logic [mjdcal_pkg::SOD_W-1:0]  sod_ms,
  output mjdcal_pkg::tod_t              tod
);

  logic [mjdcal_pkg::SOD_W-1:0] ms1_r;
  logic [5:0]                   hq1_r, hq1_nxt;
  logic [47:0]                  h_prod;
  logic [21:0]                  remh2_r, remh2_nxt;
  logic [5:0]                   hr2_r, hr2_nxt;
  logic [mjdcal_pkg::SOD_W-1:0] h_rem;
  logic [21:0]                  remh3_r;
  logic [5:0]                   hr3_r;
  logic [6:0]                   mq3_r, mq3_nxt;
  logic [38:0]                  m_prod;
  logic [21:0]                  m_rem;
  mjdcal_pkg::tod_t             tod4_r, tod4_nxt;
  mjdcal_pkg::tod_t             tod_r;

  // stage 1: hour estimate, may be one low
  always_comb begin
    h_prod  = 48'(sod_ms) * 48'(mjdcal_pkg::RECIP_HOUR);
    hq1_nxt = h_prod[47:42];
  end

  // stage 2: hour correction and remainder within the hour
  always_comb begin
    h_rem     = ms1_r - mjdcal_pkg::SOD_W'(hq1_r * mjdcal_pkg::MS_HOUR);
    hr2_nxt   = hq1_r;
    remh2_nxt = h_rem[21:0];
    if (h_rem >= mjdcal_pkg::MS_HOUR) begin
      hr2_nxt   = hq1_r + 6'd1;
      remh2_nxt = 22'(h_rem - mjdcal_pkg::MS_HOUR);
    end
  end

  // stage 3: minute estimate
  always_comb begin
    m_prod  = 39'(remh2_r) * 39'(mjdcal_pkg::RECIP_MIN);
    mq3_nxt = m_prod[38:32];
  end

  // stage 4: minute correction, hour wraps to five bits past the day
  always_comb begin
    m_rem              = remh3_r - 22'(mq3_r * mjdcal_pkg::MS_MINUTE);
    tod4_nxt.hour      = hr3_r[4:0];
    tod4_nxt.minute    = mq3_r[5:0];
    tod4_nxt.second_ms = m_rem[15:0];
    if (m_rem >= mjdcal_pkg::MS_MINUTE) begin
      tod4_nxt.minute    = 6'(mq3_r + 7'd1);
      tod4_nxt.second_ms = 16'(m_rem - mjdcal_pkg::MS_MINUTE);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ms1_r   <= sod_ms;
      hq1_r   <= hq1_nxt;
      remh2_r <= remh2_nxt;
      hr2_r   <= hr2_nxt;
      remh3_r <= remh2_r;
      hr3_r   <= hr2_r;
      mq3_r   <= mq3_nxt;
      tod4_r  <= tod4_nxt;
      tod_r   <= tod4_r;
    end
  end

  assign tod = tod_r;

endmodule

// File: hdl/mjd_to_calendar_date.sv
// ---------------------------------------------------------------------------
// mjd_to_calendar_date: modified julian date and time of day to calendar
//
// The input stream carries one timestamp per transaction: a modified julian
// date and the time of day in milliseconds. The output stream returns one
// transaction per input with the gregorian year, day of year, month, day,
// hour, minute and milliseconds within the minute.
// Each input transaction passes the register stages listed below, and
// out_tvalid rises with its result. A new transaction is taken every cycle
// unless out_tready stalls the pipeline. The depth is set by the date path:
// year estimate, its correction, three january 1 candidates, the year
// choice and the month split each take one register stage, with the time
// of day path padded to match.
// The whole pipeline advances together. When the receiver holds out_tready
// low with a result waiting, every stage freezes and in_tready falls, so
// nothing is dropped or repeated.
// Synchronous active low reset clears the stage valid bits only; the
// output shows no transaction until fresh input has flowed through.
// ---------------------------------------------------------------------------
module mjd_to_calendar_date (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // mjd[16:0], sod_ms[43:17], zero[47:44]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata   // year[11:0], day_of_year[20:12], month[24:21],
                                  // day[29:25], hour[34:30], minute[40:35],
                                  // second_ms[56:41], zero[63:57]
);

  localparam int DEPTH = mjdcal_pkg::PIPE_DEPTH;

  logic [DEPTH-1:0]  vld_r, vld_nxt;
  logic              adv;
  mjdcal_pkg::date_t date;
  mjdcal_pkg::tod_t  tod;

  assign adv       = !vld_r[DEPTH-1] || out_tready;
  assign in_tready = adv;

  always_comb begin
    vld_nxt = vld_r;
    if (adv) begin
      vld_nxt = {vld_r[DEPTH-2:0], in_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  mjdcal_date u_date (
    .clk  (clk),
    .en   (adv),
    .mjd  (in_tdata[16:0]),
    .date (date)
  );

  mjdcal_tod u_tod (
    .clk    (clk),
    .en     (adv),
    .sod_ms (in_tdata[43:17]),
    .tod    (tod)
  );

  assign out_tvalid = vld_r[DEPTH-1];
  assign out_tdata  = {7'd0, tod.second_ms, tod.minute, tod.hour,
                       date.day, date.month, date.day_of_year, date.year};

endmodule
